>>> rtl/tng_pkg.sv
// Shared constants and helpers for the threshold neighbour graph block.
package tng_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    localparam int COORD_W      = 16;
    localparam int RADIUS_W     = 15;
    localparam int INDEX_W      = 6;
    localparam int MASK_W       = 64;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 72;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd16384;

    // Width of a squared distance or of the squared cap, whichever is wider.
    function automatic int dist_width(input int cb);
        dist_width = (2 * cb + 4 > 32) ? 2 * cb + 4 : 32;
    endfunction

endpackage

>>> rtl/tng_store.sv
// Point memory: one write port and one registered read port.
module tng_store #(
    parameter int DEPTH  = tng_pkg::MAX_POINTS_DEF,
    parameter int DATA_W = 3 * tng_pkg::COORD_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);
    import tng_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/tng_dist_unit.sv
// Squared distance unit: one shared multiplier, one axis per cycle.
module tng_dist_unit #(
    parameter int COORD_BITS = tng_pkg::COORD_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       start,
    input  logic [3*COORD_BITS-1:0]                    a_pt,
    input  logic [3*COORD_BITS-1:0]                    b_pt,
    output logic                                       done,
    output logic [tng_pkg::dist_width(COORD_BITS)-1:0] dist_sq
);
    import tng_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = dist_width(COORD_BITS);
    localparam int SW = 2 * CB + 2;

    logic signed [CB:0]   diff_reg [3];
    logic [1:0]           phase_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [SW-1:0]        prod_reg;
    logic [DW-1:0]        acc_reg;
    logic signed [CB:0]   mul_in;
    logic signed [SW-1:0] mul_out;

    // Operand select for the shared squarer.
    always_comb begin
        case (phase_reg)
            2'd0:    mul_in = diff_reg[0];
            2'd1:    mul_in = diff_reg[1];
            default: mul_in = diff_reg[2];
        endcase
        mul_out = SW'(mul_in) * SW'(mul_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end else if (start) begin
            for (int k = 0; k < 3; k++) begin
                diff_reg[k] <= (CB+1)'($signed(a_pt[k*CB +: CB]))
                             - (CB+1)'($signed(b_pt[k*CB +: CB]));
            end
            acc_reg   <= '0;
            phase_reg <= 2'd0;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end else if (busy_reg) begin
            prod_reg <= SW'(mul_out);
            if (phase_reg != 2'd0) begin
                acc_reg <= acc_reg + DW'(prod_reg);
            end
            if (phase_reg == 2'd3) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            phase_reg <= phase_reg + 2'd1;
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done    = done_reg;
    assign dist_sq = acc_reg;

endmodule

>>> rtl/threshold_neighbor_graph.sv
// Top level of the threshold neighbour graph block: load, sequencer and output register.
//
// Usage. Points arrive as requests on the s_ stream; each carries x, y and z
// in s_tdata and s_tlast marks the final point of a set. Up to MAX_POINTS
// points are kept; further points are dropped, although a final marker on
// one still starts the computation. After the final point the block stops
// taking requests and runs two passes over all ordered point pairs with one
// shared squared-distance unit: the first finds each point's nearest
// neighbour (capped at twice sphere_radius) and keeps the largest of these,
// the second links every pair closer than twice that distance. One request
// per point then leaves on the m_ stream: point index and neighbour mask in
// m_tdata, m_tlast on the mask of the final point.
// Flow. Loading accepts one point per cycle. Pairs are evaluated one at a
// time; each is a memory read, an operand latch, three multiplies through
// the single squarer and the accumulate. s_tready is high only while
// loading. If the receiver stalls, the sequencer waits with the next mask
// until the output register is free. The user must write the radius through
// cfg_we and cfg_wdata only while the block is idle; the block itself does
// not enforce this. Reset empties the set, clears the output register and
// restores the radius to 16384.
module threshold_neighbor_graph #(
    parameter int MAX_POINTS = tng_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = tng_pkg::COORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Radius register.
    input  logic                             cfg_we,
    input  logic [tng_pkg::RADIUS_W-1:0]     cfg_wdata,
    // Point stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tng_pkg::S_TDATA_W-1:0]    s_tdata,  // coord_x, coord_y, coord_z
    input  logic                             s_tlast,  // last_point
    // Mask stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tng_pkg::M_TDATA_W-1:0]    m_tdata,  // point_index, neighbor_mask, zero pad
    output logic                             m_tlast   // last_result
);
    import tng_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int XW = (CB > COORD_W) ? CB : COORD_W;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = dist_width(COORD_BITS);
    localparam int MP = MAX_POINTS;
    localparam int CW = 2 * (RADIUS_W + 1);

    // Sequencer states.
    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_RDI  = 3'd1;
    localparam logic [2:0] ST_GETI = 3'd2;
    localparam logic [2:0] ST_RDJ  = 3'd3;
    localparam logic [2:0] ST_DIST = 3'd4;
    localparam logic [2:0] ST_WAIT = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0]          state_reg;
    logic [AW:0]         count_reg;
    logic [AW:0]         n_reg;
    logic [AW-1:0]       i_reg;
    logic [AW-1:0]       j_reg;
    logic                pass_reg;
    logic [DW-1:0]       cap_reg;
    logic [DW-1:0]       mn_reg;
    logic [DW-1:0]       best_reg;
    logic [DW-1:0]       max_nearest_reg;
    logic [MP-1:0]       mask_reg;
    logic [3*CB-1:0]     pi_reg;

    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [MASK_W-1:0]   out_mask_reg;
    logic                out_last_reg;

    logic                in_accept;
    logic                store_en;
    logic [AW-1:0]       rd_addr;
    logic [3*CB-1:0]     rd_data;
    logic [3*CB-1:0]     wr_pt;
    logic [XW-1:0]       x_w;
    logic [XW-1:0]       y_w;
    logic [XW-1:0]       z_w;
    logic                dist_start;
    logic                dist_done;
    logic [DW-1:0]       dist_sq;
    logic                self_pair;
    logic                row_end;
    logic                last_row;
    logic [DW-1:0]       mn_next;
    logic [DW-1:0]       best_next;
    logic [MP-1:0]       mask_next;
    logic [DW+1:0]       lim;
    logic                out_free;
    logic [RADIUS_W:0]   cap_root;

    // The store keeps the low COORD_BITS of each coordinate; the distance
    // unit sign-extends them again.
    assign x_w   = XW'(s_tdata[COORD_W-1:0]);
    assign y_w   = XW'(s_tdata[2*COORD_W-1:COORD_W]);
    assign z_w   = XW'(s_tdata[3*COORD_W-1:2*COORD_W]);
    assign wr_pt = {z_w[CB-1:0], y_w[CB-1:0], x_w[CB-1:0]};

    assign s_tready  = (state_reg == ST_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign store_en  = in_accept && (count_reg < (AW+1)'(MP));

    assign rd_addr    = (state_reg == ST_RDI) ? i_reg : j_reg;
    assign dist_start = (state_reg == ST_DIST);

    tng_store #(
        .DEPTH  (MP),
        .DATA_W (3 * CB)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_pt),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tng_dist_unit #(
        .COORD_BITS (CB)
    ) u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dist_start),
        .a_pt    (pi_reg),
        .b_pt    (rd_data),
        .done    (dist_done),
        .dist_sq (dist_sq)
    );

    // Pair bookkeeping for the result coming back from the distance unit.
    assign self_pair = (j_reg == i_reg);
    assign row_end   = ((AW+1)'(j_reg) == n_reg - (AW+1)'(1));
    assign last_row  = ((AW+1)'(i_reg) == n_reg - (AW+1)'(1));
    assign lim       = {max_nearest_reg, 2'b00};
    assign mn_next   = (!self_pair && dist_sq < mn_reg) ? dist_sq : mn_reg;
    assign best_next = (mn_next > best_reg) ? mn_next : best_reg;
    assign mask_next = (!self_pair && (DW+2)'(dist_sq) < lim)
                     ? (mask_reg | (MP'(1) << j_reg)) : mask_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign cap_root = {cfg_wdata, 1'b0};

    // Squared cap is worked out once when the radius is written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= DW'(CW'({RADIUS_RESET, 1'b0}) * CW'({RADIUS_RESET, 1'b0}));
        end else if (cfg_we) begin
            cap_reg <= DW'(CW'(cap_root) * CW'(cap_root));
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            count_reg       <= '0;
            max_nearest_reg <= '0;
            pass_reg        <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (in_accept) begin
                        if (store_en) begin
                            count_reg <= count_reg + (AW+1)'(1);
                        end
                        if (s_tlast) begin
                            n_reg     <= store_en ? count_reg + (AW+1)'(1) : count_reg;
                            i_reg     <= '0;
                            pass_reg  <= 1'b0;
                            best_reg  <= '0;
                            state_reg <= ST_RDI;
                        end
                    end
                end
                ST_RDI: begin
                    mn_reg    <= cap_reg;
                    mask_reg  <= '0;
                    j_reg     <= '0;
                    state_reg <= ST_GETI;
                end
                ST_GETI: begin
                    pi_reg    <= rd_data;
                    state_reg <= ST_RDJ;
                end
                ST_RDJ: begin
                    state_reg <= ST_DIST;
                end
                ST_DIST: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (dist_done) begin
                        if (!pass_reg) begin
                            mn_reg <= mn_next;
                            if (row_end) begin
                                best_reg <= best_next;
                                if (last_row) begin
                                    max_nearest_reg <= best_next;
                                    pass_reg        <= 1'b1;
                                    i_reg           <= '0;
                                end else begin
                                    i_reg <= i_reg + AW'(1);
                                end
                                state_reg <= ST_RDI;
                            end else begin
                                j_reg     <= j_reg + AW'(1);
                                state_reg <= ST_RDJ;
                            end
                        end else begin
                            mask_reg <= mask_next;
                            if (row_end) begin
                                state_reg <= ST_EMIT;
                            end else begin
                                j_reg     <= j_reg + AW'(1);
                                state_reg <= ST_RDJ;
                            end
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (last_row) begin
                            count_reg <= '0;
                            state_reg <= ST_LOAD;
                        end else begin
                            i_reg     <= i_reg + AW'(1);
                            state_reg <= ST_RDI;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Output register: a finished mask waits here while the sequencer
    // moves on to the next row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            out_index_reg <= INDEX_W'(i_reg);
            out_mask_reg  <= MASK_W'(mask_reg);
            out_last_reg  <= last_row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_mask_reg, out_index_reg});
    assign m_tlast  = out_last_reg;

endmodule
